// ===== rtl/pcpt_pkg.sv =====
// Shared types, register indexes and reset constants for the power-cycle print trigger.
package pcpt_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int MS_W          = 16;
    localparam int NOW_W         = 32;
    localparam int IN_TDATA_W    = 40;
    localparam int OUT_TDATA_W   = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_POLL_INTERVAL = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFF_DEBOUNCE  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_TIME     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOOT_GRACE    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_DROP     = 3'd6;

    localparam logic [MS_W-1:0] RST_POLL_INTERVAL = 16'd250;
    localparam logic [MS_W-1:0] RST_OFF_DEBOUNCE  = 16'd1000;
    localparam logic [MS_W-1:0] RST_SETTLE        = 16'd3000;
    localparam logic [MS_W-1:0] RST_COOLDOWN      = 16'd15000;
    localparam logic [MS_W-1:0] RST_BOOT_GRACE    = 16'd5000;

    localparam logic [MS_W-1:0] FAST_DROP_MS = 16'd400;

    localparam logic OP_POLL = 1'b0;
    localparam logic OP_DONE = 1'b1;

    typedef struct packed {
        logic             print_success;
        logic             boot_print_pending;
        logic             portal_active;
        logic             phy_link_down;
        logic             printer_online;
        logic [NOW_W-1:0] now_ms;
    } item_t;

    typedef struct packed {
        logic seen_first_sample;
        logic last_online;
        logic print_satisfied;
        logic off_timing;
        logic ever_printed;
    } flags_t;

    typedef struct packed {
        logic poll_taken;
        logic off_confirmed;
        logic close_portal;
        logic print_request;
    } result_t;

endpackage

// ===== rtl/pcpt_core.sv =====
// Decision logic: next trigger state and result for one registered item.
module pcpt_core #(
    parameter int TIME_BITS = pcpt_pkg::TIME_BITS_DEF
) (
    input  logic [pcpt_pkg::MS_W-1:0] poll_interval_ms,
    input  logic [pcpt_pkg::MS_W-1:0] offline_debounce_ms,
    input  logic [pcpt_pkg::MS_W-1:0] settle_ms,
    input  logic [pcpt_pkg::MS_W-1:0] cooldown_ms,
    input  logic [TIME_BITS-1:0]      boot_time_ms,
    input  logic [pcpt_pkg::MS_W-1:0] boot_grace_ms,
    input  logic                      fast_drop_enable,
    input  logic                      op,
    input  pcpt_pkg::item_t           item,
    input  logic [TIME_BITS-1:0]      last_poll_time,
    input  logic [TIME_BITS-1:0]      online_since,
    input  logic [TIME_BITS-1:0]      offline_since,
    input  logic [TIME_BITS-1:0]      last_print_done,
    input  pcpt_pkg::flags_t          flags,
    output logic [TIME_BITS-1:0]      last_poll_time_next,
    output logic [TIME_BITS-1:0]      online_since_next,
    output logic [TIME_BITS-1:0]      offline_since_next,
    output logic [TIME_BITS-1:0]      last_print_done_next,
    output pcpt_pkg::flags_t          flags_next,
    output pcpt_pkg::result_t         result
);

    logic [TIME_BITS-1:0] now_t;
    logic [TIME_BITS-1:0] off_start;
    logic [TIME_BITS-1:0] on_start;
    logic [TIME_BITS-1:0] el_poll;
    logic [TIME_BITS-1:0] el_off;
    logic [TIME_BITS-1:0] el_boot;
    logic [TIME_BITS-1:0] el_done;
    logic [TIME_BITS-1:0] el_on;
    logic                 fast;
    logic                 cooling;

    assign now_t     = TIME_BITS'(item.now_ms);
    // offline timing starts now when it is not already running
    assign off_start = flags.off_timing ? offline_since : now_t;
    // online time restarts on an off-to-on edge
    assign on_start  = (item.printer_online && !flags.last_online) ? now_t : online_since;
    assign el_poll = now_t - last_poll_time;
    assign el_off  = now_t - off_start;
    assign el_boot = now_t - boot_time_ms;
    assign el_done = now_t - last_print_done;
    assign el_on   = now_t - on_start;
    assign fast    = fast_drop_enable && item.phy_link_down &&
                     (el_off >= TIME_BITS'(pcpt_pkg::FAST_DROP_MS));
    assign cooling = flags.ever_printed && (el_done < TIME_BITS'(cooldown_ms));

    always_comb
    begin
        last_poll_time_next  = last_poll_time;
        online_since_next    = online_since;
        offline_since_next   = offline_since;
        last_print_done_next = last_print_done;
        flags_next           = flags;
        result               = '0;
        if (op == pcpt_pkg::OP_DONE)
        begin
            last_print_done_next    = now_t;
            flags_next.ever_printed = 1'b1;
            if (item.print_success)
            begin
                flags_next.print_satisfied = 1'b1;
            end
        end
        else if (el_poll >= TIME_BITS'(poll_interval_ms))
        begin
            last_poll_time_next = now_t;
            result.poll_taken   = 1'b1;
            if (!flags.seen_first_sample)
            begin
                flags_next.seen_first_sample = 1'b1;
                flags_next.last_online       = item.printer_online;
                if (item.printer_online)
                begin
                    online_since_next = now_t;
                end
                else
                begin
                    offline_since_next    = now_t;
                    flags_next.off_timing = 1'b1;
                end
            end
            else if (!item.printer_online && flags.last_online)
            begin
                // drop pending: sample is not latched until confirmed
                if (!flags.off_timing)
                begin
                    offline_since_next    = now_t;
                    flags_next.off_timing = 1'b1;
                end
                if (fast || (el_off >= TIME_BITS'(offline_debounce_ms)))
                begin
                    flags_next.last_online     = 1'b0;
                    online_since_next          = '0;
                    offline_since_next         = '0;
                    flags_next.off_timing      = 1'b0;
                    flags_next.print_satisfied = 1'b0;
                    result.off_confirmed       = 1'b1;
                end
            end
            else
            begin
                if (item.printer_online && !flags.last_online)
                begin
                    online_since_next = now_t;
                end
                if (item.printer_online)
                begin
                    flags_next.off_timing = 1'b0;
                end
                if (item.printer_online && !flags.print_satisfied &&
                    (el_boot >= TIME_BITS'(boot_grace_ms)) && !cooling &&
                    (el_on >= TIME_BITS'(settle_ms)) && !item.boot_print_pending)
                begin
                    result.print_request = 1'b1;
                    result.close_portal  = item.portal_active;
                end
                flags_next.last_online = item.printer_online;
            end
        end
    end

endmodule

// ===== rtl/power_cycle_print_trigger.sv =====
// Top level of the power-cycle print trigger: stream ports, config registers, state.
// Path: an accepted item waits in the input register, then moves into the result
//   register once that register is free (input reg, result reg).
// Throughput: one item per cycle absent sink stalls; the only loop is the state update.
// Reset (rst_n low, asynchronous): both stages empty, config at its defaults,
//   trigger state cleared with print_satisfied set. No clearing pass is needed.
module power_cycle_print_trigger #(
    parameter int TIME_BITS = pcpt_pkg::TIME_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // poll / print-done input
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // tdata: [31:0] now_ms, [32] printer_online, [33] phy_link_down,
    //        [34] portal_active, [35] boot_print_pending, [36] print_success,
    //        [39:37] zero
    input  logic [pcpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // tuser: [0] op (0 poll, 1 print done)
    input  logic                             s_axis_tuser,
    // result output
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // tdata: [0] print_request, [1] close_portal, [2] off_confirmed,
    //        [3] poll_taken, [7:4] zero
    output logic [pcpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
    // configuration writes
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [pcpt_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [pcpt_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // configuration registers
    logic [pcpt_pkg::MS_W-1:0] poll_interval_reg;
    logic [pcpt_pkg::MS_W-1:0] off_debounce_reg;
    logic [pcpt_pkg::MS_W-1:0] settle_reg;
    logic [pcpt_pkg::MS_W-1:0] cooldown_reg;
    logic [TIME_BITS-1:0]      boot_time_reg;
    logic [pcpt_pkg::MS_W-1:0] boot_grace_reg;
    logic                      fast_drop_reg;

    // input stage
    logic                      in_valid_reg;
    logic                      in_op_reg;
    pcpt_pkg::item_t           in_item_reg;

    // trigger state
    logic [TIME_BITS-1:0]      last_poll_reg;
    logic [TIME_BITS-1:0]      online_since_reg;
    logic [TIME_BITS-1:0]      offline_since_reg;
    logic [TIME_BITS-1:0]      last_done_reg;
    pcpt_pkg::flags_t          flags_reg;

    logic [TIME_BITS-1:0]      last_poll_next;
    logic [TIME_BITS-1:0]      online_since_next;
    logic [TIME_BITS-1:0]      offline_since_next;
    logic [TIME_BITS-1:0]      last_done_next;
    pcpt_pkg::flags_t          flags_next;
    pcpt_pkg::result_t         result_next;

    // result stage
    logic                      out_valid_reg;
    pcpt_pkg::result_t         out_result_reg;

    logic                      out_free;
    logic                      advance;
    logic                      in_xact;

    // The result register frees up whenever the sink takes its transaction,
    // so the input stage moves on in the same cycle.
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && out_free;
    assign s_axis_tready = !in_valid_reg || out_free;
    assign in_xact       = s_axis_tvalid && s_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(pcpt_pkg::OUT_TDATA_W - 4){1'b0}}, out_result_reg};
    assign cfg_ready     = 1'b1;

    // config writes must arrive only while the block is idle; the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            poll_interval_reg <= pcpt_pkg::RST_POLL_INTERVAL;
            off_debounce_reg  <= pcpt_pkg::RST_OFF_DEBOUNCE;
            settle_reg        <= pcpt_pkg::RST_SETTLE;
            cooldown_reg      <= pcpt_pkg::RST_COOLDOWN;
            boot_time_reg     <= '0;
            boot_grace_reg    <= pcpt_pkg::RST_BOOT_GRACE;
            fast_drop_reg     <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                pcpt_pkg::CFG_POLL_INTERVAL: poll_interval_reg <= cfg_data[15:0];
                pcpt_pkg::CFG_OFF_DEBOUNCE:  off_debounce_reg  <= cfg_data[15:0];
                pcpt_pkg::CFG_SETTLE:        settle_reg        <= cfg_data[15:0];
                pcpt_pkg::CFG_COOLDOWN:      cooldown_reg      <= cfg_data[15:0];
                pcpt_pkg::CFG_BOOT_TIME:     boot_time_reg     <= TIME_BITS'(cfg_data);
                pcpt_pkg::CFG_BOOT_GRACE:    boot_grace_reg    <= cfg_data[15:0];
                pcpt_pkg::CFG_FAST_DROP:     fast_drop_reg     <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_xact)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xact)
        begin
            in_op_reg   <= s_axis_tuser;
            in_item_reg <= pcpt_pkg::item_t'(s_axis_tdata[36:0]);
        end
    end

    pcpt_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .poll_interval_ms     (poll_interval_reg),
        .offline_debounce_ms  (off_debounce_reg),
        .settle_ms            (settle_reg),
        .cooldown_ms          (cooldown_reg),
        .boot_time_ms         (boot_time_reg),
        .boot_grace_ms        (boot_grace_reg),
        .fast_drop_enable     (fast_drop_reg),
        .op                   (in_op_reg),
        .item                 (in_item_reg),
        .last_poll_time       (last_poll_reg),
        .online_since         (online_since_reg),
        .offline_since        (offline_since_reg),
        .last_print_done      (last_done_reg),
        .flags                (flags_reg),
        .last_poll_time_next  (last_poll_next),
        .online_since_next    (online_since_next),
        .offline_since_next   (offline_since_next),
        .last_print_done_next (last_done_next),
        .flags_next           (flags_next),
        .result               (result_next)
    );

    // state commits when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_poll_reg     <= '0;
            online_since_reg  <= '0;
            offline_since_reg <= '0;
            last_done_reg     <= '0;
            flags_reg         <= '{seen_first_sample: 1'b0, last_online: 1'b0,
                                   print_satisfied: 1'b1, off_timing: 1'b0,
                                   ever_printed: 1'b0};
        end
        else if (advance)
        begin
            last_poll_reg     <= last_poll_next;
            online_since_reg  <= online_since_next;
            offline_since_reg <= offline_since_next;
            last_done_reg     <= last_done_next;
            flags_reg         <= flags_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the power-cycle print trigger.
`timescale 1ns / 100ps

module tb;

    // ---------------------------------------------------------------------
    // Run control
    // ---------------------------------------------------------------------
    localparam int CYCLE_LIMIT  = 200000;   // generous upper bound on a run
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 50;
    localparam int ZERO_PHASE   = 1;        // every register at its minimum
    localparam int MAX_PHASE    = 5;        // every register at its maximum
    localparam int HOLD_PHASE   = 5;        // long receiver hold-off, sender never idles
    localparam int HOLD_CYCLES  = 200;
    localparam int TAIL_CYCLES  = 8;        // settling margin after the last result
    localparam int MAX_PRINTED  = 40;

    // index past the register list; writes to it must be ignored
    localparam logic [pcpt_pkg::CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    // one queued transaction for the input side
    typedef struct packed {
        logic            op;
        pcpt_pkg::item_t fields;
    } stim_t;

    // ---------------------------------------------------------------------
    // DUT signals; every input known from time zero
    // ---------------------------------------------------------------------
    logic                             clk            = 1'b0;
    logic                             rst_n          = 1'b0;
    logic                             s_axis_tvalid  = 1'b0;
    logic                             s_axis_tready;
    logic [pcpt_pkg::IN_TDATA_W-1:0]  s_axis_tdata   = '0;
    logic                             s_axis_tuser   = pcpt_pkg::OP_POLL;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready  = 1'b0;
    logic [pcpt_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                             cfg_valid      = 1'b0;
    logic                             cfg_ready;
    logic [pcpt_pkg::CFG_IDX_W-1:0]   cfg_index      = pcpt_pkg::CFG_POLL_INTERVAL;
    logic [pcpt_pkg::CFG_DATA_W-1:0]  cfg_data       = '0;

    power_cycle_print_trigger uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // tdata: [31:0] now_ms, [32] printer_online, [33] phy_link_down,
        //        [34] portal_active, [35] boot_print_pending, [36] print_success
        .s_axis_tdata  (s_axis_tdata),
        // tuser: [0] op
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // tdata: [0] print_request, [1] close_portal, [2] off_confirmed, [3] poll_taken
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // 8 ns period
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // ---------------------------------------------------------------------
    // Shadow of the trigger: register copy and decision state
    // ---------------------------------------------------------------------
    logic [pcpt_pkg::MS_W-1:0]  poll_iv       = pcpt_pkg::RST_POLL_INTERVAL;
    logic [pcpt_pkg::MS_W-1:0]  debounce      = pcpt_pkg::RST_OFF_DEBOUNCE;
    logic [pcpt_pkg::MS_W-1:0]  settle        = pcpt_pkg::RST_SETTLE;
    logic [pcpt_pkg::MS_W-1:0]  cooldown      = pcpt_pkg::RST_COOLDOWN;
    logic [pcpt_pkg::NOW_W-1:0] boot_stamp    = '0;
    logic [pcpt_pkg::MS_W-1:0]  grace         = pcpt_pkg::RST_BOOT_GRACE;
    logic                       fast_en       = 1'b0;

    logic [pcpt_pkg::NOW_W-1:0] last_poll     = '0;
    logic [pcpt_pkg::NOW_W-1:0] online_since  = '0;
    logic [pcpt_pkg::NOW_W-1:0] offline_since = '0;
    logic [pcpt_pkg::NOW_W-1:0] last_done     = '0;
    logic                       seen_first    = 1'b0;
    logic                       last_on       = 1'b0;
    logic                       satisfied     = 1'b1;   // nothing owed until a drop
    logic                       off_timing    = 1'b0;
    logic                       ever_printed  = 1'b0;

    // wrapping elapsed time
    function automatic logic [pcpt_pkg::NOW_W-1:0] ms_since(
        input logic [pcpt_pkg::NOW_W-1:0] now,
        input logic [pcpt_pkg::NOW_W-1:0] stamp);
        return now - stamp;
    endfunction

    // Decision for one accepted transaction; advances the shadow state.
    function automatic pcpt_pkg::result_t decide_trigger(input logic op,
                                                         input pcpt_pkg::item_t it);
        pcpt_pkg::result_t          r;
        logic [pcpt_pkg::NOW_W-1:0] now;
        logic                       online;
        logic                       fast;
        logic                       cooling;
        r      = '0;
        now    = it.now_ms;
        online = it.printer_online;
        if (op == pcpt_pkg::OP_DONE)
        begin
            // print-done: timestamp only, poll timer untouched, no outputs
            last_done    = now;
            ever_printed = 1'b1;
            if (it.print_success)
                satisfied = 1'b1;
            return r;
        end
        if (ms_since(now, last_poll) < poll_iv)
            return r;                    // too soon: dropped, nothing changes
        last_poll    = now;
        r.poll_taken = 1'b1;
        if (!seen_first)
        begin
            // first sample is only latched
            seen_first = 1'b1;
            last_on    = online;
            if (online)
                online_since = now;
            else
            begin
                offline_since = now;
                off_timing    = 1'b1;
            end
            return r;
        end
        if (online && !last_on)
        begin
            online_since = now;
            off_timing   = 1'b0;
        end
        else if (!online && last_on)
        begin
            // drop pending: sample not latched, no print this poll
            if (!off_timing)
            begin
                offline_since = now;
                off_timing    = 1'b1;
            end
            fast = fast_en && it.phy_link_down &&
                   ms_since(now, offline_since) >= pcpt_pkg::FAST_DROP_MS;
            if (fast || ms_since(now, offline_since) >= debounce)
            begin
                last_on         = 1'b0;
                online_since    = '0;
                offline_since   = '0;
                off_timing      = 1'b0;
                satisfied       = 1'b0;
                r.off_confirmed = 1'b1;
            end
            return r;
        end
        if (online)
            off_timing = 1'b0;
        if (online && !satisfied && ms_since(now, boot_stamp) >= grace)
        begin
            cooling = ever_printed && ms_since(now, last_done) < cooldown;
            if (!cooling && ms_since(now, online_since) >= settle && !it.boot_print_pending)
            begin
                r.print_request = 1'b1;
                r.close_portal  = it.portal_active;
            end
        end
        last_on = online;
        return r;
    endfunction

    // ---------------------------------------------------------------------
    // Bookkeeping
    // ---------------------------------------------------------------------
    stim_t             poll_feed[$];        // transactions waiting to be offered
    pcpt_pkg::result_t pending_verdicts[$]; // expected results, oldest first
    int unsigned pushed_cnt     = 0;
    int unsigned accepted_cnt   = 0;
    int unsigned result_cnt     = 0;
    int unsigned mismatches     = 0;
    int unsigned cycle_cnt      = 0;
    int          phase_no       = -1;
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_off       = 1'b0;
    logic        in_taken       = 1'b0;
    logic [pcpt_pkg::NOW_W-1:0] t_cursor = '0;

    task automatic report_mismatch(input string what, input logic [3:0] got,
                                   input logic [3:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTED)
            $display("[%0t] result %0d %s: got %b want %b",
                     $realtime, result_cnt, what, got, want);
    endtask

    // ---------------------------------------------------------------------
    // Input driver: changes on the falling edge, pulls from poll_feed
    // ---------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_items
        stim_t nxt;
        if (rst_n && (!s_axis_tvalid || in_taken))
        begin
            if (poll_feed.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = poll_feed.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {3'b000, nxt.fields};
                s_axis_tuser  <= nxt.op;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin : drive_ready
        m_axis_tready <= rst_n && !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // ---------------------------------------------------------------------
    // Monitor: check the result transaction first, then predict for the
    // input transaction taken on the same edge.
    // ---------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        pcpt_pkg::result_t got;
        pcpt_pkg::result_t want;
        pcpt_pkg::item_t   it;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[3:0];
            if (pending_verdicts.size() == 0)
                report_mismatch("unexpected result", got, 4'b0000);
            else
            begin
                want = pending_verdicts.pop_front();
                if (got.print_request !== want.print_request)
                    report_mismatch("print_request", 4'(got.print_request),
                                    4'(want.print_request));
                if (got.close_portal !== want.close_portal)
                    report_mismatch("close_portal", 4'(got.close_portal),
                                    4'(want.close_portal));
                if (got.off_confirmed !== want.off_confirmed)
                    report_mismatch("off_confirmed", 4'(got.off_confirmed),
                                    4'(want.off_confirmed));
                if (got.poll_taken !== want.poll_taken)
                    report_mismatch("poll_taken", 4'(got.poll_taken),
                                    4'(want.poll_taken));
            end
            result_cnt++;
        end
        in_taken = rst_n && s_axis_tvalid && s_axis_tready;
        if (in_taken)
        begin
            it = s_axis_tdata[36:0];
            pending_verdicts.push_back(decide_trigger(s_axis_tuser, it));
            accepted_cnt++;
        end
    end

    // Watchdog
    always @(posedge clk)
    begin : watchdog
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_cnt, pending_verdicts.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // Long receiver hold-off while the sender keeps offering, so the
    // pipeline fills and input tready drops.
    initial
    begin : long_stall
        wait (phase_no == HOLD_PHASE);
        @(posedge clk);
        hold_off = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off = 1'b0;
    end

    // ---------------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------------
    task automatic add_poll(input logic [pcpt_pkg::NOW_W-1:0] dt, input logic online,
                            input logic phy_down, input logic portal, input logic boot_pend);
        stim_t s;
        t_cursor                    += dt;
        s.op                        = pcpt_pkg::OP_POLL;
        s.fields.now_ms             = t_cursor;
        s.fields.printer_online     = online;
        s.fields.phy_link_down      = phy_down;
        s.fields.portal_active      = portal;
        s.fields.boot_print_pending = boot_pend;
        s.fields.print_success      = 1'($urandom);   // ignored on a poll
        poll_feed.push_back(s);
        pushed_cnt++;
    endtask

    task automatic add_done(input logic [pcpt_pkg::NOW_W-1:0] dt, input logic success);
        stim_t s;
        t_cursor                    += dt;
        s.op                        = pcpt_pkg::OP_DONE;
        s.fields.now_ms             = t_cursor;
        s.fields.printer_online     = 1'($urandom);   // poll-only fields are noise here
        s.fields.phy_link_down      = 1'($urandom);
        s.fields.portal_active      = 1'($urandom);
        s.fields.boot_print_pending = 1'($urandom);
        s.fields.print_success      = success;
        poll_feed.push_back(s);
        pushed_cnt++;
    endtask

    // Register write; shadow copy follows at the accepting edge.
    task automatic write_reg(input logic [pcpt_pkg::CFG_IDX_W-1:0] idx,
                             input logic [pcpt_pkg::CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            pcpt_pkg::CFG_POLL_INTERVAL: poll_iv    = data[pcpt_pkg::MS_W-1:0];
            pcpt_pkg::CFG_OFF_DEBOUNCE:  debounce   = data[pcpt_pkg::MS_W-1:0];
            pcpt_pkg::CFG_SETTLE:        settle     = data[pcpt_pkg::MS_W-1:0];
            pcpt_pkg::CFG_COOLDOWN:      cooldown   = data[pcpt_pkg::MS_W-1:0];
            pcpt_pkg::CFG_BOOT_TIME:     boot_stamp = data[pcpt_pkg::NOW_W-1:0];
            pcpt_pkg::CFG_BOOT_GRACE:    grace      = data[pcpt_pkg::MS_W-1:0];
            pcpt_pkg::CFG_FAST_DROP:     fast_en    = data[0];
            default: ;
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Wait until every offered transaction has its result back.
    task automatic drain_verdicts();
        while (accepted_cnt != pushed_cnt || pending_verdicts.size() != 0)
            @(negedge clk);
        repeat (TAIL_CYCLES) @(negedge clk);
    endtask

    // Registers for one random phase; upper data bits are junk that must be dropped.
    task automatic setup_phase(input int p, output int unsigned span);
        logic [pcpt_pkg::MS_W-1:0]  v_poll, v_deb, v_settle, v_cool, v_grace;
        logic [pcpt_pkg::NOW_W-1:0] v_boot;
        logic                       v_fast;
        if (p == ZERO_PHASE)
        begin
            {v_poll, v_deb, v_settle, v_cool, v_grace} = '0;
            v_boot = '0;
            v_fast = 1'b0;
            span   = 1500;
        end
        else if (p == MAX_PHASE)
        begin
            {v_poll, v_deb, v_settle, v_cool, v_grace} = '1;
            v_boot = '1;
            v_fast = 1'b1;
            span   = 140000;
        end
        else
        begin
            v_poll   = 16'($urandom_range(0, 400));
            v_deb    = 16'($urandom_range(0, 1500));
            v_settle = 16'($urandom_range(0, 2500));
            v_cool   = 16'($urandom_range(0, 4000));
            v_grace  = 16'($urandom_range(0, 3000));
            v_boot   = t_cursor + $urandom_range(0, 3000);
            v_fast   = 1'($urandom);
            span     = 1500;
        end
        write_reg(pcpt_pkg::CFG_POLL_INTERVAL, {16'($urandom), v_poll});
        write_reg(pcpt_pkg::CFG_OFF_DEBOUNCE,  {16'($urandom), v_deb});
        write_reg(pcpt_pkg::CFG_SETTLE,        {16'($urandom), v_settle});
        write_reg(pcpt_pkg::CFG_COOLDOWN,      {16'($urandom), v_cool});
        write_reg(pcpt_pkg::CFG_BOOT_TIME,     v_boot);
        write_reg(pcpt_pkg::CFG_BOOT_GRACE,    {16'($urandom), v_grace});
        write_reg(pcpt_pkg::CFG_FAST_DROP,     {31'($urandom), v_fast});
    endtask

    // ---------------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------------
    initial
    begin : run_test
        int unsigned                span;
        logic                       online;
        logic [pcpt_pkg::NOW_W-1:0] dt;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // Directed part with the reset register values
        @(posedge clk);
        phase_no = 0;
        add_poll(32'd100,  1'b1, 1'b0, 1'b0, 1'b0);   // too soon after time zero
        add_poll(32'd200,  1'b1, 1'b0, 1'b0, 1'b0);   // first sample latched
        add_poll(32'd100,  1'b1, 1'b0, 1'b0, 1'b0);   // inside poll interval
        add_poll(32'd4900, 1'b1, 1'b0, 1'b1, 1'b0);   // online but nothing owed
        add_poll(32'd300,  1'b0, 1'b0, 1'b0, 1'b0);   // drop starts timing
        add_poll(32'd1100, 1'b0, 1'b0, 1'b0, 1'b0);   // debounce met: re-armed
        add_poll(32'd300,  1'b1, 1'b0, 1'b1, 1'b0);   // back online, not settled
        add_poll(32'd3000, 1'b1, 1'b0, 1'b1, 1'b1);   // boot print pending blocks
        add_poll(32'd300,  1'b1, 1'b0, 1'b1, 1'b0);   // fires with portal close
        add_poll(32'd300,  1'b1, 1'b0, 1'b0, 1'b0);   // no done yet: fires again
        add_done(32'd100,  1'b0);                     // failed print stays armed
        add_poll(32'd200,  1'b1, 1'b0, 1'b1, 1'b0);   // cooldown holds it
        add_done(32'd100,  1'b1);                     // success disarms
        add_poll(32'd15500, 1'b1, 1'b0, 1'b1, 1'b0);
        add_poll(32'd500,  1'b0, 1'b1, 1'b0, 1'b0);   // phy down but fast rule off
        add_poll(32'd300,  1'b1, 1'b0, 1'b0, 1'b0);   // drop abandoned
        add_poll(32'hFFFF_F000, 1'b1, 1'b1, 1'b1, 1'b1); // timestamp wraps
        drain_verdicts();

        // Registers at their extremes, fast drop on
        write_reg(pcpt_pkg::CFG_POLL_INTERVAL, 32'hFFFF_0000);
        write_reg(pcpt_pkg::CFG_OFF_DEBOUNCE,  32'h0000_FFFF);
        write_reg(pcpt_pkg::CFG_SETTLE,        32'h0000_0000);
        write_reg(pcpt_pkg::CFG_COOLDOWN,      32'h0000_0000);
        write_reg(pcpt_pkg::CFG_BOOT_TIME,     32'hFFFF_FFFF);
        write_reg(pcpt_pkg::CFG_BOOT_GRACE,    32'h0000_0000);
        write_reg(pcpt_pkg::CFG_FAST_DROP,     32'hFFFF_FFFF);
        write_reg(CFG_UNUSED,                  $urandom);
        @(posedge clk);
        add_poll(32'd0,   1'b0, 1'b1, 1'b0, 1'b0);    // zero interval: same time accepted
        add_poll(32'd399, 1'b0, 1'b1, 1'b0, 1'b0);    // one short of fast drop
        add_poll(32'd1,   1'b0, 1'b1, 1'b0, 1'b0);    // fast drop confirms
        add_poll(32'd0,   1'b1, 1'b0, 1'b1, 1'b0);    // zero settle fires at once
        add_poll(32'd0,   1'b1, 1'b0, 1'b1, 1'b1);
        add_done(32'd0,   1'b1);
        add_poll(32'd0,   1'b1, 1'b0, 1'b1, 1'b0);
        add_poll(32'd0,   1'b0, 1'b0, 1'b0, 1'b0);    // long debounce, no phy: pends
        drain_verdicts();

        // Random phases: realistic power cycles with noise mixed in
        for (int p = 1; p <= RAND_PHASES; p++)
        begin
            setup_phase(p, span);
            @(posedge clk);
            phase_no = p;
            case ((p - 1) % 4)
                0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1:       begin send_idle_pct = 56; recv_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  recv_stall_pct = 56; end
                default: begin send_idle_pct = 24; recv_stall_pct = 24; end
            endcase
            online = 1'($urandom);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if ($urandom_range(99) < 15)
                    add_done($urandom_range(0, 300), $urandom_range(99) < 70);
                else
                begin
                    if ($urandom_range(99) < 20)
                        online = !online;
                    if ($urandom_range(99) < 4)
                        dt = $urandom;              // far jump, exercises wrap
                    else
                        dt = $urandom_range(0, span);
                    add_poll(dt, online, 1'($urandom), 1'($urandom),
                             $urandom_range(99) < 15);
                end
            end
            drain_verdicts();
        end

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
